### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the note trigger decoder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed: invariant");

// antecedent on one edge implies consequent on the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/mntd_pkg.sv
// ----------------------------------------------------------------------------
// mntd_pkg
// shared types, constants and helpers of the note trigger decoder
// ----------------------------------------------------------------------------
package mntd_pkg;

  localparam int NUM_TRACKS  = 16;
  localparam int TRK_W       = 4;
  localparam int NOTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // high nibble of the status byte
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_CHANNEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_NOTES_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_NOTES_HIGH = 2'd2;

  typedef logic [NUM_TRACKS-1:0] track_mask_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

  // index of the lowest set bit, zero when none
  function automatic logic [TRK_W-1:0] lowest_set(input track_mask_t m);
    logic [TRK_W-1:0] idx;
    idx = '0;
    for (int i = NUM_TRACKS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = TRK_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### hdl/mntd_front.sv
// ----------------------------------------------------------------------------
// mntd_front
// byte parser: running status tracking and trigger note match
// ----------------------------------------------------------------------------
module mntd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  input  logic [3:0]                       listen_channel,
  input  logic [mntd_pkg::CFG_DATA_W-1:0]  track_notes_low,
  input  logic [mntd_pkg::CFG_DATA_W-1:0]  track_notes_high,
  input  mntd_pkg::q_stat_t                q_stat,
  output logic                             push,
  output mntd_pkg::track_mask_t            push_mask
);
  import mntd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NOTE,
    PH_VEL
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [7:0]               status_r, status_nxt;
  logic [NOTE_W-1:0]        note_r, note_nxt;
  logic [2*CFG_DATA_W-1:0]  notes_all;
  track_mask_t              match;
  logic                     accept;
  logic                     is_status;
  logic                     fire;

  assign in_ready  = q_stat.not_full;
  assign accept    = in_valid && in_ready;
  assign notes_all = {track_notes_high, track_notes_low};
  assign is_status = (in_rx_byte[7:4] == KIND_NOTE_ON) || (in_rx_byte[7:4] == KIND_NOTE_OFF);

  // compare held note against every track's trigger note
  always_comb begin
    for (int t = 0; t < NUM_TRACKS; t++) begin
      match[t] = (notes_all[NOTE_W*t +: NOTE_W] == note_r);
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    note_nxt   = note_r;
    fire       = 1'b0;
    if (accept) begin
      if (is_status) begin
        status_nxt = in_rx_byte;
        phase_nxt  = PH_NOTE;
      end else begin
        case (phase_r)
          PH_NOTE: begin
            note_nxt  = in_rx_byte;
            phase_nxt = PH_VEL;
          end
          PH_VEL: begin
            phase_nxt = PH_NOTE;
            fire      = (status_r[7:4] == KIND_NOTE_ON) && (in_rx_byte != 8'd0) &&
                        (status_r[3:0] == listen_channel);
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // only messages that hit at least one track reach the queue
  assign push      = fire && (|match);
  assign push_mask = match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      status_r <= '0;
      note_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      note_r   <= note_nxt;
    end
  end

endmodule

### hdl/mntd_queue.sv
// ----------------------------------------------------------------------------
// mntd_queue
// short fifo of track match masks between parser and emitter
// ----------------------------------------------------------------------------
module mntd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mntd_pkg::track_mask_t push_mask,
  input  logic                  pop,
  output mntd_pkg::track_mask_t head_mask,
  output mntd_pkg::q_stat_t     q_stat
);
  import mntd_pkg::*;

  track_mask_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head_mask        = slot_r[rd_ptr_r];
  assign q_stat.not_full  = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_stat.not_empty = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/mntd_back.sv
// ----------------------------------------------------------------------------
// mntd_back
// trigger emitter: walks a match mask from track 0 upwards, while out_ready allows one word a cycle
// ----------------------------------------------------------------------------
module mntd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mntd_pkg::track_mask_t        head_mask,
  input  mntd_pkg::q_stat_t            q_stat,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mntd_pkg::TRK_W-1:0]   out_track_index,
  output logic                         out_last_of_run
);
  import mntd_pkg::*;

  track_mask_t       run_r, run_nxt;
  logic              valid_r, valid_nxt;
  logic [TRK_W-1:0]  track_r, track_nxt;
  logic              last_r, last_nxt;
  track_mask_t       src;
  track_mask_t       rest;
  logic              advance;
  logic              have_src;

  assign advance  = !valid_r || out_ready;
  assign have_src = (run_r != '0) || q_stat.not_empty;
  // unfinished run first, else the next queued mask
  assign src      = (run_r != '0) ? run_r : head_mask;
  assign rest     = src & (src - 1'b1);
  assign pop      = advance && (run_r == '0) && q_stat.not_empty;

  always_comb begin
    run_nxt   = run_r;
    valid_nxt = valid_r;
    track_nxt = track_r;
    last_nxt  = last_r;
    if (advance) begin
      valid_nxt = have_src;
      if (have_src) begin
        track_nxt = lowest_set(src);
        last_nxt  = (rest == '0);
        run_nxt   = rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      run_r   <= run_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    track_r <= track_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_track_index = track_r;
  assign out_last_of_run = last_r;

endmodule

### hdl/midi_note_trigger_decoder.sv
// a completing velocity byte's mask is queued, then the emitter registers its first word
// throughput: one byte word accepted per cycle while the four-entry match queue has room
// a triggering message drains one track word per cycle while out_ready is high, one per track
// reset: synchronous active-low rst_n clears phase, held status, queue and config registers
// ----------------------------------------------------------------------------
// midi_note_trigger_decoder
// parses received note status/data bytes with running status and emits one
// trigger word per track whose note matches a note-on on the listened channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_note_trigger_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // byte input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  // trigger output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mntd_pkg::TRK_W-1:0]       out_track_index,
  output logic                             out_last_of_run,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mntd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mntd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mntd_pkg::*;

  // configuration registers
  logic [3:0]             listen_channel_r;
  logic [CFG_DATA_W-1:0]  track_notes_low_r;
  logic [CFG_DATA_W-1:0]  track_notes_high_r;
  logic                   cfg_we;

  // front to queue to back
  logic         push;
  track_mask_t  push_mask;
  logic         pop;
  track_mask_t  head_mask;
  q_stat_t      q_stat;

  // writes are always taken; indexes past the list are dropped
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_channel_r   <= '0;
      track_notes_low_r  <= '0;
      track_notes_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LISTEN_CHANNEL:   listen_channel_r   <= cfg_data[3:0];
        CFG_TRACK_NOTES_LOW:  track_notes_low_r  <= cfg_data;
        CFG_TRACK_NOTES_HIGH: track_notes_high_r <= cfg_data;
        default: begin
          listen_channel_r <= listen_channel_r;
        end
      endcase
    end
  end

  // front: status tracking and note match, pushes a mask per triggering message
  mntd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .listen_channel   (listen_channel_r),
    .track_notes_low  (track_notes_low_r),
    .track_notes_high (track_notes_high_r),
    .q_stat           (q_stat),
    .push             (push),
    .push_mask        (push_mask)
  );

  // decoupling queue of match masks
  mntd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_mask (push_mask),
    .pop       (pop),
    .head_mask (head_mask),
    .q_stat    (q_stat)
  );

  // back: one trigger word per matching track, ascending
  mntd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_mask       (head_mask),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_track_index (out_track_index),
    .out_last_of_run (out_last_of_run)
  );

  // the parser never pushes into a full queue
  `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !push || q_stat.not_full)
  // the emitter never pops an empty queue
  `ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !pop || q_stat.not_empty)
  // a word that is not the last of its run is followed by another at once
  `ASSERT_NEXT(a_run_continues, clk, rst_n,
    out_valid && out_ready && !out_last_of_run, out_valid)
  // tracks within a run come out in ascending order
  `ASSERT_NEXT(a_run_ascends, clk, rst_n,
    out_valid && out_ready && !out_last_of_run,
    out_track_index > $past(out_track_index))

endmodule

### dv/tb_midi_note_trigger_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_note_trigger_decoder
// self-checking bench: byte words go in through valid/ready, every track word
// that comes out is checked against table rows or a behavioural decoder in the bench;
// a directed table comes first, then random phases under several settings
// ----------------------------------------------------------------------------
module tb_midi_note_trigger_decoder;
  import mntd_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 8;     // covers the queue and emitter registers plus queue slack
  localparam int HOLD_CYCLES    = 160;   // long output stall, fills the match queue
  localparam int DRAIN_LIMIT    = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_BYTES    = 45;
  localparam longint TIMEOUT_NS = 3_000_000;

  // index past the register list, the block ignores it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {PH_IDLE, PH_NOTE, PH_VEL} parse_phase_t;

  typedef struct packed {
    logic [TRK_W-1:0] track;
    logic             last;
  } trig_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [7:0]             rx;
    int unsigned            n_trig;     // typed rows: number of track words
    int unsigned            first_trk;  // typed rows: tracks run upwards from here
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [TRK_W-1:0]      out_track_index;
  logic                  out_last_of_run;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // bench copy of the decoder state and registers
  parse_phase_t          parse_phase;
  logic [7:0]            held_status;
  logic [7:0]            held_note;
  logic [3:0]            chan_reg;
  logic [CFG_DATA_W-1:0] notes_lo_reg;
  logic [CFG_DATA_W-1:0] notes_hi_reg;

  trig_t       trig_hits[$];       // words caused by the last decoded byte
  trig_t       pending_trigs[$];   // words still owed by the block, oldest first

  // stimulus control shared by both sides
  logic        gapless;
  logic        hold_req;
  logic        long_hold;

  int unsigned bytes_sent;
  int unsigned words_checked;
  int unsigned cfg_writes;
  int unsigned errors;

  midi_note_trigger_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_track_index (out_track_index),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioural decoder
  // ---------------------------------------------------------------------------

  // advance the parser by one byte, leave the matching tracks in trig_hits
  function automatic void decode_byte(input logic [7:0] b);
    logic [2*CFG_DATA_W-1:0] all_notes;
    trig_t                   hit;
    logic [7:0]              velocity;
    trig_hits.delete();
    // note on / note off status restarts collection, whatever came before
    if (b[7:4] == KIND_NOTE_ON || b[7:4] == KIND_NOTE_OFF) begin
      held_status = b;
      parse_phase = PH_NOTE;
      return;
    end
    if (parse_phase == PH_NOTE) begin
      held_note   = b;
      parse_phase = PH_VEL;
      return;
    end
    // data with no status seen yet is dropped
    if (parse_phase != PH_VEL) return;
    velocity    = b;
    parse_phase = PH_NOTE;   // running status
    if (held_status[7:4] != KIND_NOTE_ON || velocity == 8'h00 ||
        held_status[3:0] != chan_reg) return;
    all_notes = {notes_hi_reg, notes_lo_reg};
    for (int t = 0; t < NUM_TRACKS; t++) begin
      // all eight bits compared, so notes above 127 can match
      if (all_notes[8*t +: 8] == held_note) begin
        hit.track = TRK_W'(t);
        hit.last  = 1'b0;
        trig_hits.push_back(hit);
      end
    end
    if (trig_hits.size() != 0) trig_hits[trig_hits.size()-1].last = 1'b1;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LISTEN_CHANNEL:   chan_reg     = data[3:0];
      CFG_TRACK_NOTES_LOW:  notes_lo_reg = data;
      CFG_TRACK_NOTES_HIGH: notes_hi_reg = data;
      default: ;   // unused index, nothing changes
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // table rows
  // ---------------------------------------------------------------------------

  function automatic stim_row_t pred_row(input logic [7:0] b);
    stim_row_t r;
    r.kind = ROW_PREDICT;
    r.rx = b;
    r.n_trig = 0;
    r.first_trk = 0;
    r.idx = CFG_LISTEN_CHANNEL;
    r.data = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input int unsigned n,
                                          input int unsigned first);
    stim_row_t r;
    r = pred_row(b);
    r.kind = ROW_TYPED;
    r.n_trig = n;
    r.first_trk = first;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = pred_row(8'h00);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // data byte: anything but a note status
  function automatic logic [7:0] rand_data();
    int unsigned v;
    v = $urandom_range(0, 223);
    if (v >= 'h80) v = v + 'h20;
    return 8'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one byte word, return at the edge that takes it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    bytes_sent++;
  endtask

  // feed the accepted byte to the decoder and queue what it owes
  task automatic send_predicted(input logic [7:0] b);
    send_byte(b);
    decode_byte(b);
    foreach (trig_hits[k]) pending_trigs.push_back(trig_hits[k]);
  endtask

  // stop offering, let every owed word come out, then let the pipe empty
  task automatic settle_all();
    int unsigned guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_trigs.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    // bytes that owe nothing may still sit in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called once the block has gone quiet
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_cfg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random ready, long hold-off on request, compare every word
  // ---------------------------------------------------------------------------

  initial begin : trig_sink
    int unsigned idle_left;
    logic        took;
    trig_t       want;
    out_ready = 1'b0;
    idle_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      took = out_valid && out_ready;
      if (took) begin
        words_checked++;
        if (pending_trigs.size() == 0) begin
          $display("%0t: unexpected track word, expected none, actual track %0d last %0b",
                   $time, out_track_index, out_last_of_run);
          errors++;
        end else begin
          want = pending_trigs.pop_front();
          if (out_track_index !== want.track) begin
            $display("%0t: track_index mismatch, expected %0d, actual %0d",
                     $time, want.track, out_track_index);
            errors++;
          end
          if (out_last_of_run !== want.last) begin
            $display("%0t: last_of_run mismatch on track %0d, expected %0b, actual %0b",
                     $time, want.track, want.last, out_last_of_run);
            errors++;
          end
        end
      end
      @(negedge clk);
      if (took) idle_left = gapless ? 0 : $urandom_range(0, 4);
      if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= !long_hold;
      end
    end
  end

  // long receiver stall, counted here so the sender keeps pushing meanwhile
  initial begin : stall_timer
    long_hold = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
    end
  end

  // hard stop if the block hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout after %0d ns, %0d track words still owed", TIMEOUT_NS,
             pending_trigs.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : byte_source
    stim_row_t             directed_rows[$];
    trig_t                 t;
    logic [7:0]            note_pool[4];
    logic [3:0]            chan;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] rnd64;
    logic [7:0]            st;
    int unsigned           phase_start;
    int unsigned           r;
    logic                  have_status;
    logic                  paused;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_LISTEN_CHANNEL;
    cfg_data   = '0;
    gapless    = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    words_checked = 0;
    cfg_writes = 0;
    errors     = 0;

    parse_phase  = PH_IDLE;
    held_status  = 8'h00;
    held_note    = 8'h00;
    chan_reg     = 4'h0;
    notes_lo_reg = '0;
    notes_hi_reg = '0;

    // directed table
    // reset settings: channel 0, every track on note 0
    directed_rows.push_back(typed_row(8'h45, 0, 0));   // data before any status
    directed_rows.push_back(typed_row(8'h00, 0, 0));
    directed_rows.push_back(typed_row(8'h90, 0, 0));
    directed_rows.push_back(typed_row(8'h00, 0, 0));
    directed_rows.push_back(typed_row(8'h7F, 16, 0));  // every track fires
    directed_rows.push_back(typed_row(8'h00, 0, 0));   // running status
    directed_rows.push_back(typed_row(8'h00, 0, 0));   // zero velocity
    directed_rows.push_back(typed_row(8'h80, 0, 0));   // note off
    directed_rows.push_back(typed_row(8'h00, 0, 0));
    directed_rows.push_back(typed_row(8'h7F, 0, 0));
    // channel 5 (upper bits must be dropped), mixed trigger notes
    directed_rows.push_back(cfg_row(CFG_LISTEN_CHANNEL, 64'hFFFF_FFFF_FFFF_FFF5));
    directed_rows.push_back(cfg_row(CFG_TRACK_NOTES_LOW, 64'hFF3C_3C10_2030_4000));
    directed_rows.push_back(cfg_row(CFG_TRACK_NOTES_HIGH, 64'h3C11_1213_1415_1617));
    directed_rows.push_back(cfg_row(CFG_UNUSED, '1));
    directed_rows.push_back(typed_row(8'h95, 0, 0));
    directed_rows.push_back(typed_row(8'hFF, 0, 0));   // note above 127
    directed_rows.push_back(typed_row(8'h01, 1, 7));
    directed_rows.push_back(pred_row(8'h3C));           // shared note, three tracks
    directed_rows.push_back(pred_row(8'h40));
    directed_rows.push_back(typed_row(8'h96, 0, 0));   // foreign channel
    directed_rows.push_back(typed_row(8'h3C, 0, 0));
    directed_rows.push_back(typed_row(8'h40, 0, 0));
    directed_rows.push_back(typed_row(8'h95, 0, 0));
    directed_rows.push_back(typed_row(8'h00, 0, 0));
    directed_rows.push_back(typed_row(8'hF8, 1, 0));   // realtime byte taken as velocity
    directed_rows.push_back(typed_row(8'h9F, 0, 0));   // highest channel, not listened
    directed_rows.push_back(typed_row(8'h3C, 0, 0));
    directed_rows.push_back(typed_row(8'h40, 0, 0));

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          settle_all();
          write_cfg(directed_rows[i].idx, directed_rows[i].data);
        end
        ROW_TYPED: begin
          send_byte(directed_rows[i].rx);
          decode_byte(directed_rows[i].rx);   // keeps the parser in step
          for (int k = 0; k < directed_rows[i].n_trig; k++) begin
            t.track = TRK_W'(directed_rows[i].first_trk + k);
            t.last  = (k == directed_rows[i].n_trig - 1);
            pending_trigs.push_back(t);
          end
        end
        default: send_predicted(directed_rows[i].rx);
      endcase
    end
    settle_all();

    // random phases, each under its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        // top channel, every track on the top note
        chan = 4'hF;
        foreach (note_pool[k]) note_pool[k] = 8'hFF;
      end else if (ph == 1) begin
        chan = 4'h0;
        foreach (note_pool[k]) note_pool[k] = 8'h00;
      end else begin
        chan = 4'($urandom);
        foreach (note_pool[k]) note_pool[k] = rand_data();
      end
      for (int trk = 0; trk < NUM_TRACKS; trk++) begin
        if (trk < 8) lo[8*trk +: 8] = note_pool[$urandom_range(0, 3)];
        else         hi[8*(trk-8) +: 8] = note_pool[$urandom_range(0, 3)];
      end
      rnd64 = {$urandom, $urandom};
      write_cfg(CFG_LISTEN_CHANNEL, {rnd64[CFG_DATA_W-1:4], chan});
      write_cfg(CFG_TRACK_NOTES_LOW, lo);
      write_cfg(CFG_TRACK_NOTES_HIGH, hi);
      if (ph % 2 == 1) write_cfg(CFG_UNUSED, {$urandom, $urandom});

      // phase 2: receiver stalls long while bytes keep coming back to back
      // phase 3: no idling on either side
      gapless = (ph == 2 || ph == 3);
      if (ph == 2) hold_req = 1'b1;

      phase_start = bytes_sent;
      have_status = 1'b0;
      paused      = 1'b0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          // well-formed message, running status now and then
          if (!have_status || $urandom_range(0, 2) == 0) begin
            st[7:4] = ($urandom_range(0, 4) == 0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            st[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom) : chan;
            send_predicted(st);
            have_status = 1'b1;
          end
          send_predicted(($urandom_range(0, 5) == 0) ? rand_data()
                                                     : note_pool[$urandom_range(0, 3)]);
          send_predicted(($urandom_range(0, 9) == 0) ? 8'h00 : rand_data());
        end else if (r < 90) begin
          // noise, any byte at all
          send_predicted(8'($urandom));
        end else begin
          // broken message: status and note, no velocity sent here
          st[7:4] = ($urandom_range(0, 1) == 0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
          st[3:0] = chan;
          send_predicted(st);
          send_predicted(note_pool[$urandom_range(0, 3)]);
          have_status = 1'b1;
        end
        // sender waits mid-phase until everything owed has come out
        if (!paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
          settle_all();
          paused = 1'b1;
        end
      end
      gapless = 1'b0;
      settle_all();
    end

    if (pending_trigs.size() != 0) begin
      $display("%0t: %0d track words never arrived", $time, pending_trigs.size());
    end
    $display("covered %0d bytes, %0d track words checked, %0d register writes",
             bytes_sent, words_checked, cfg_writes);
    $display("settings from channel 0 to 15, all-zero and all-0xFF notes, %0d-cycle stall",
             HOLD_CYCLES);
    if (errors == 0 && pending_trigs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### midi_note_trigger_decoder.f
+incdir+hdl
hdl/mntd_pkg.sv
hdl/mntd_front.sv
hdl/mntd_queue.sv
hdl/mntd_back.sv
hdl/midi_note_trigger_decoder.sv
dv/tb_midi_note_trigger_decoder.sv
